>>> rtl/mm2kh_pkg.sv
// Shared types and hash constants for the MurmurHash2 key hasher.
`default_nettype none

package mm2kh_pkg;

  // Hash constants
  localparam logic [31:0] SEED  = 32'd5381;
  localparam logic [31:0] MUL   = 32'h5bd1e995;
  localparam int unsigned SHIFT = 24;
  localparam int unsigned FIN1  = 13;
  localparam int unsigned FIN2  = 15;

  // One input chunk
  typedef struct packed {
    logic [30:0] key_length;
    logic [31:0] chunk_data;
    logic [2:0]  chunk_bytes;
    logic        first_chunk;
    logic        last_chunk;
  } in_t;

  // One finished hash
  typedef struct packed {
    logic [31:0] hash_value;
    logic [31:0] bucket_index;
    logic        chunk_error;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/murmur2_key_hash.sv
// MurmurHash2 key hasher top level: sequencer around one constant multiplier.
// A full chunk passes through the transfer, MK2, MH and MIX, set by the three
// dependent multiplies through the single shared multiplier.
// A tail chunk passes through the transfer, MT and MIX, an empty chunk only the transfer;
// a last chunk adds FIN and DONE (finish, output load) before its result is in the output register.
// Synchronous active-high reset clears the hash, error and last flags and out_valid, and sets the mask to 15.
`default_nettype none

module murmur2_key_hash (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mm2kh_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output mm2kh_pkg::out_t      out_data,
  input  wire logic            cfg_we,
  input  wire logic [31:0]     cfg_wdata
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MK2  = 8'b0000_0010,
    ST_MH   = 8'b0000_0100,
    ST_MT   = 8'b0000_1000,
    ST_MIX  = 8'b0001_0000,
    ST_FIN  = 8'b0010_0000,
    ST_DONE = 8'b0100_0000,
    ST_SPARE = 8'b1000_0000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] p;
  logic        last;
  logic        err;
  logic [31:0] bucket_mask;
  logic [31:0] mul_a;
  logic [31:0] keep;
  logic [2:0]  nbytes;
  logic        accept;
  logic        out_load;
  logic [31:0] fin_hash;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);
  assign fin_hash = p ^ (p >> mm2kh_pkg::FIN2);

  // Saturate the byte count and build the tail byte mask
  always_comb begin
    nbytes = in_data.chunk_bytes[2] ? 3'd4 : in_data.chunk_bytes;
    unique case (in_data.chunk_bytes[1:0])
      2'd1:    keep = 32'h0000_00ff;
      2'd2:    keep = 32'h0000_ffff;
      2'd3:    keep = 32'h00ff_ffff;
      default: keep = 32'h0000_0000;
    endcase
  end

  // Select the multiplier operand for this step
  always_comb begin
    unique case (state)
      ST_IDLE: mul_a = in_data.chunk_data;
      ST_MK2:  mul_a = p ^ (p >> mm2kh_pkg::SHIFT);
      ST_MH:   mul_a = h;
      ST_MT:   mul_a = h ^ k;
      ST_FIN:  mul_a = h ^ (h >> mm2kh_pkg::FIN1);
      default: mul_a = 32'd0;
    endcase
  end

  // Sequence the steps of one chunk
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (nbytes == 3'd4) begin
            state_next = ST_MK2;
          end else if (nbytes != 3'd0) begin
            state_next = ST_MT;
          end else if (in_data.last_chunk) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_MK2:  state_next = ST_MH;
      ST_MH:   state_next = ST_MIX;
      ST_MT:   state_next = ST_MIX;
      ST_MIX:  state_next = last ? ST_FIN : ST_IDLE;
      ST_FIN:  state_next = ST_DONE;
      ST_DONE: state_next = out_load ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and control registers
  always_ff @(posedge clk) begin
    // Hold the finish product while the result waits for the output register
    if (state != ST_DONE) begin
      p <= 32'(mul_a * mm2kh_pkg::MUL);
    end
    if (rst) begin
      state       <= ST_IDLE;
      h           <= 32'd0;
      err         <= 1'b0;
      last        <= 1'b0;
      bucket_mask <= 32'd15;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        bucket_mask <= cfg_wdata;
      end
      // Start or continue the running hash on a transfer
      if (accept) begin
        last <= in_data.last_chunk;
        k    <= in_data.chunk_data & keep;
        if (in_data.first_chunk) begin
          h <= mm2kh_pkg::SEED ^ {1'b0, in_data.key_length};
        end
        if (nbytes != 3'd4 && !in_data.last_chunk) begin
          err <= 1'b1;
        end else if (in_data.first_chunk) begin
          err <= 1'b0;
        end
      end
      // Hold the key product while the hash is multiplied
      if (state == ST_MH) begin
        k <= p;
      end
      // Drop the tail word once folded into the product
      if (state == ST_MT) begin
        k <= 32'd0;
      end
      if (state == ST_MIX) begin
        h <= p ^ k;
      end
      // Hand the result to the output register
      if (out_load) begin
        out_valid             <= 1'b1;
        out_data.hash_value   <= fin_hash;
        out_data.bucket_index <= fin_hash & bucket_mask;
        out_data.chunk_error  <= err;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept && (nbytes != 3'd0 || in_data.last_chunk) |=> !in_ready)
    else $error("input ready right after a transfer");

  a_bucket_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.bucket_index == (out_data.hash_value & bucket_mask)))
    else $error("bucket index does not match hash and mask");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && in_ready)
    else $error("finished hash not presented");
`endif

endmodule

`default_nettype wire

>>> verif/murmur2_key_hash_test.sv
// Self-checking testbench for the MurmurHash2 key hasher with a bucket mask.
module murmur2_key_hash_test;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  mm2kh_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  mm2kh_pkg::out_t out_data;
  logic            cfg_we = 1'b0;
  logic [31:0]     cfg_wdata = '0;

  // Stimulus and scoreboard state
  mm2kh_pkg::in_t  chunks_to_send[$];
  mm2kh_pkg::out_t hashes_due[$];
  logic        in_fire = 1'b0;
  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned items_made = 0;

  // Shadow of the block's state and mask register
  logic [31:0] hash_acc = '0;
  bit          short_seen = 1'b0;
  logic [31:0] mask_shadow = 32'd15;

  murmur2_key_hash u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fold one chunk into the shadow hash; finish it on a last chunk
  function automatic void murmur_fold(input mm2kh_pkg::in_t c, output bit emit,
                                      output mm2kh_pkg::out_t res);
    logic [31:0] h;
    logic [31:0] k;
    logic [31:0] keep;
    logic [31:0] f;
    logic [2:0]  n;
    n = (c.chunk_bytes > 3'd4) ? 3'd4 : c.chunk_bytes;
    if (c.first_chunk) begin
      h = mm2kh_pkg::SEED ^ {1'b0, c.key_length};
      short_seen = 1'b0;
    end else begin
      h = hash_acc;
    end
    if (n == 3'd4) begin
      k = c.chunk_data * mm2kh_pkg::MUL;
      k = k ^ (k >> mm2kh_pkg::SHIFT);
      k = k * mm2kh_pkg::MUL;
      h = (h * mm2kh_pkg::MUL) ^ k;
    end else if (n != 3'd0) begin
      // drop data bytes past the tail length
      keep = 32'hFFFF_FFFF >> (8 * (4 - n));
      h = (h ^ (c.chunk_data & keep)) * mm2kh_pkg::MUL;
    end
    if (n < 3'd4 && !c.last_chunk) short_seen = 1'b1;
    hash_acc = h;
    emit = c.last_chunk;
    res = '0;
    if (emit) begin
      f = h ^ (h >> mm2kh_pkg::FIN1);
      f = f * mm2kh_pkg::MUL;
      f = f ^ (f >> mm2kh_pkg::FIN2);
      res.hash_value   = f;
      res.bucket_index = f & mask_shadow;
      res.chunk_error  = short_seen;
    end
  endfunction

  task automatic push_chunk(input logic [30:0] len, input logic [31:0] data,
                            input logic [2:0] nbytes, input bit first, input bit last);
    mm2kh_pkg::in_t c;
    c.key_length  = len;
    c.chunk_data  = data;
    c.chunk_bytes = nbytes;
    c.first_chunk = first;
    c.last_chunk  = last;
    chunks_to_send.push_back(c);
    items_made++;
  endtask

  // Queue one key as chunks; a broken key opens with a short non-last chunk
  task automatic push_key(input int unsigned key_bytes, input bit broken);
    int unsigned left;
    int unsigned n;
    logic [2:0]  nb;
    bit          head;
    logic [30:0] len;
    left = key_bytes;
    head = 1'b1;
    len = ($urandom_range(9) == 0) ? 31'($urandom()) : 31'(key_bytes);
    if (broken) begin
      push_chunk(len, $urandom(), 3'($urandom_range(3)), 1'b1, 1'b0);
      head = 1'b0;
    end
    forever begin
      n = (left > 4) ? 4 : left;
      nb = 3'(n);
      if (n == 4 && $urandom_range(7) == 0) nb = 3'($urandom_range(7, 5));
      push_chunk(head ? len : 31'($urandom()), $urandom(), nb, head, left <= 4);
      head = 1'b0;
      if (left <= 4) break;
      left = left - 4;
    end
  endtask

  // Wait until every transfer is done and every result is in
  task automatic drain();
    while (chunks_to_send.size() != 0 || in_valid || hashes_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_mask(input logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    mask_shadow = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input driver: hold a chunk until transfer, then load the next or idle
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (chunks_to_send.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
        in_data  <= chunks_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output backpressure
  always @(negedge clk) begin
    out_ready <= !rst && (calm || $urandom_range(99) >= 31);
  end

  // Monitor: check results, then predict from accepted chunks
  always @(posedge clk) begin : watch
    mm2kh_pkg::out_t want;
    mm2kh_pkg::out_t res;
    bit   emit;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (hashes_due.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = hashes_due.pop_front();
          if (out_data.hash_value !== want.hash_value) begin
            $display("%0t: hash_value expected %h actual %h", $time,
                     want.hash_value, out_data.hash_value);
            mismatches++;
          end
          if (out_data.bucket_index !== want.bucket_index) begin
            $display("%0t: bucket_index expected %h actual %h", $time,
                     want.bucket_index, out_data.bucket_index);
            mismatches++;
          end
          if (out_data.chunk_error !== want.chunk_error) begin
            $display("%0t: chunk_error expected %b actual %b", $time,
                     want.chunk_error, out_data.chunk_error);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        murmur_fold(in_data, emit, res);
        if (emit) hashes_due.push_back(res);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] masks[5];
    int unsigned goal;
    int unsigned pick;
    masks[0] = 32'h0000_0000;
    masks[1] = 32'hFFFF_FFFF;
    masks[2] = $urandom();
    masks[3] = 32'h0000_03FF;
    masks[4] = 32'h8000_0001;

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: no first chunk straight after reset continues from a zero hash
    push_chunk(31'd0, 32'hDEAD_BEEF, 3'd4, 1'b0, 1'b1);
    // empty key, field extremes
    push_chunk(31'd0, 32'h0000_0000, 3'd0, 1'b1, 1'b1);
    push_chunk(31'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1);
    push_chunk(31'd4, 32'h0000_0000, 3'd4, 1'b1, 1'b1);
    push_chunk(31'h2AAA_AAAA, 32'h5555_5555, 3'd4, 1'b1, 1'b1);
    // oversized byte counts saturate to a full chunk
    push_chunk(31'd4, 32'h0102_0304, 3'd5, 1'b1, 1'b1);
    push_chunk(31'd4, 32'h0102_0304, 3'd6, 1'b1, 1'b1);
    push_chunk(31'd4, 32'h0102_0304, 3'd7, 1'b1, 1'b1);
    // tails with junk in the unused bytes
    push_chunk(31'd1, 32'hFFFF_FFFF, 3'd1, 1'b1, 1'b1);
    push_chunk(31'd2, 32'hFFFF_FFFF, 3'd2, 1'b1, 1'b1);
    push_chunk(31'd3, 32'hFFFF_FFFF, 3'd3, 1'b1, 1'b1);
    // early short chunk, then a continuation after the last chunk keeps the error
    push_chunk(31'd6, 32'hA5A5_1234, 3'd2, 1'b1, 1'b0);
    push_chunk(31'd6, 32'h89AB_CDEF, 3'd4, 1'b0, 1'b1);
    push_chunk(31'd0, 32'h1357_9BDF, 3'd4, 1'b0, 1'b1);
    // early empty chunk
    push_chunk(31'd8, 32'h0F0F_0F0F, 3'd0, 1'b1, 1'b0);
    push_chunk(31'd8, 32'hF0F0_F0F0, 3'd4, 1'b0, 1'b1);
    // length that does not match the bytes sent
    push_chunk(31'd100, 32'h00C0_FFEE, 3'd3, 1'b1, 1'b1);
    // well-formed three-chunk key
    push_chunk(31'd9, 32'h6867_6665, 3'd4, 1'b1, 1'b0);
    push_chunk(31'd9, 32'h6C6B_6A69, 3'd4, 1'b0, 1'b0);
    push_chunk(31'd9, 32'hFFFF_FF6D, 3'd1, 1'b0, 1'b1);
    drain();

    // Random phases, one mask each; the sender pauses at every boundary
    for (int p = 0; p < 5; p++) begin
      set_mask(masks[p]);
      calm = (p == 2);
      goal = items_made + 150;
      while (items_made < goal) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          push_key(($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(12), 1'b0);
        end else if (pick < 90) begin
          push_key($urandom_range(16), 1'b1);
        end else begin
          push_chunk(31'($urandom()), $urandom(), 3'($urandom_range(7)),
                     1'($urandom()), 1'($urandom()));
        end
      end
      drain();
    end

    if (mismatches == 0 && hashes_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
